[rtl/core/trfd_pkg.sv]
// Shared types and constants for the touch report frame decoder.
`default_nettype none

package trfd_pkg;

  // Default limit on contacts in one report.
  localparam int unsigned MaxContactsDefault = 10;

  // Reset value of the rotation pivot.
  localparam logic [11:0] PivotReset = 12'd1847;

  // Report layout.
  localparam logic [7:0] HdrLen     = 8'd8;
  localparam logic [7:0] HdrSumLen  = 8'd6;
  localparam logic [7:0] PosStatus  = 8'd0;
  localparam logic [7:0] PosRequest = 8'd2;
  localparam logic [7:0] PosChkLow  = 8'd6;
  localparam logic [7:0] PosChkHigh = 8'd7;
  localparam logic [3:0] RecMajor   = 4'd4;

  // Header bits and codes.
  localparam int unsigned StatusTouchBit   = 7;
  localparam int unsigned StatusRequestBit = 6;
  localparam logic [7:0]  RequestReset     = 8'h03;
  localparam logic [1:0]  ActionRelease    = 2'd3;

  typedef enum logic [2:0] {
    KIND_CONTACT   = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_HDR_ERR   = 3'd2,
    KIND_BAD_COUNT = 3'd3,
    KIND_RESET_REQ = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic        active;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  touch_major;
    logic        data_checksum_ok;
    logic        last;
  } result_t;

  // Results produced by one byte: up to two, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } emit_t;

endpackage

`default_nettype wire

[rtl/core/trfd_decode.sv]
// Report parser: header and record state, and the results each byte produces.
`default_nettype none

module trfd_decode #(
  parameter int unsigned MAX_CONTACTS = trfd_pkg::MaxContactsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire trfd_pkg::item_t      item_i,
  input  wire logic [11:0]          pivot_i,
  output trfd_pkg::emit_t           emit_o
);

  localparam logic [4:0] MaxC = 5'(MAX_CONTACTS);

  logic [7:0]  byte_pos_q, byte_pos_d;
  logic        in_report_q, in_report_d;
  logic [15:0] hsum_q, hsum_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  request_q, request_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  chk_q, chk_d;
  logic [15:0] rsum_q, rsum_d;
  logic [7:0]  head_q [4];
  logic [7:0]  head_d [4];

  logic        live;
  logic [7:0]  pos;
  logic [7:0]  off;
  logic [7:0]  span;
  logic [3:0]  w;
  logic [7:0]  b;
  logic        close;
  logic        a_vld;
  logic        rst_emit;
  trfd_pkg::result_t res_a;
  logic        reset_wanted;
  logic [3:0]  hdr_cnt;
  logic [3:0]  c_slot;
  logic [1:0]  c_act;
  logic [11:0] raw_x;
  logic [11:0] raw_y;
  trfd_pkg::result_t rst_res;

  assign b     = item_i.data_byte;
  assign live  = item_i.frame_start || in_report_q;
  assign pos   = item_i.frame_start ? 8'd0 : byte_pos_q;
  assign off   = pos - trfd_pkg::HdrLen;
  assign span  = {cnt_q, 4'b0000};
  assign w     = off[3:0];
  assign reset_wanted = status_q[trfd_pkg::StatusRequestBit] &&
                        (request_q == trfd_pkg::RequestReset);
  assign hdr_cnt = request_q[3:0];
  assign c_slot  = head_q[0][5:2];
  assign c_act   = head_q[0][7:6];
  assign raw_x   = {head_q[1], head_q[3][7:4]};
  assign raw_y   = {head_q[2], head_q[3][3:0]};

  always_comb begin
    rst_res      = '0;
    rst_res.kind = trfd_pkg::KIND_RESET_REQ;
  end

  always_comb begin
    byte_pos_d  = byte_pos_q;
    in_report_d = in_report_q;
    hsum_d      = hsum_q;
    status_d    = status_q;
    request_d   = request_q;
    cnt_d       = cnt_q;
    chk_d       = chk_q;
    rsum_d      = rsum_q;
    head_d      = head_q;
    close       = 1'b0;
    a_vld       = 1'b0;
    rst_emit    = 1'b0;
    res_a       = '0;

    if (step_i && live) begin
      byte_pos_d = pos + 8'd1;
      if (pos < trfd_pkg::HdrLen) begin
        if (pos == trfd_pkg::PosStatus) begin
          hsum_d = {8'h00, b};
        end else if (pos < trfd_pkg::HdrSumLen) begin
          hsum_d = hsum_q + {8'h00, b};
        end
        if (pos == trfd_pkg::PosStatus) begin
          status_d = b;
          if (b == 8'h00) begin
            close = 1'b1;
          end
        end else if (pos == trfd_pkg::PosRequest) begin
          request_d = b;
        end else if (pos == trfd_pkg::PosChkLow) begin
          chk_d = b;
        end else if (pos == trfd_pkg::PosChkHigh) begin
          if (hsum_q != {b, chk_q}) begin
            a_vld      = 1'b1;
            res_a.kind = trfd_pkg::KIND_HDR_ERR;
            close      = 1'b1;
          end else if (status_q[trfd_pkg::StatusTouchBit]) begin
            if ({1'b0, hdr_cnt} > MaxC) begin
              a_vld      = 1'b1;
              res_a.kind = trfd_pkg::KIND_BAD_COUNT;
              rst_emit   = reset_wanted;
              close      = 1'b1;
            end else if (hdr_cnt == 4'd0) begin
              a_vld                  = 1'b1;
              res_a.kind             = trfd_pkg::KIND_DONE;
              res_a.data_checksum_ok = 1'b1;
              rst_emit               = reset_wanted;
              close                  = 1'b1;
            end else begin
              cnt_d = hdr_cnt;
            end
          end else begin
            rst_emit = reset_wanted;
            close    = 1'b1;
          end
        end
      end else if (off < span) begin
        rsum_d = (off == 8'd0) ? {8'h00, b} : rsum_q + {8'h00, b};
        if (w < 4'd4) begin
          head_d[w[1:0]] = b;
        end
        // Bytes zero to three are held; byte four completes the contact.
        if (w == trfd_pkg::RecMajor && head_q[0][1:0] == 2'b00 &&
            {1'b0, c_slot} < MaxC) begin
          a_vld      = 1'b1;
          res_a.kind = trfd_pkg::KIND_CONTACT;
          res_a.slot = c_slot;
          if (c_act != trfd_pkg::ActionRelease) begin
            res_a.active      = 1'b1;
            res_a.pos_x       = raw_y;
            res_a.pos_y       = (pivot_i >= raw_x) ? pivot_i - raw_x : 12'd0;
            res_a.touch_major = b;
          end
        end
      end else if (off == span) begin
        chk_d = b;
      end else begin
        a_vld                  = 1'b1;
        res_a.kind             = trfd_pkg::KIND_DONE;
        res_a.data_checksum_ok = (rsum_q == {b, chk_q});
        rst_emit               = reset_wanted;
        close                  = 1'b1;
      end
      in_report_d = !close;
    end
  end

  always_comb begin
    emit_o = '0;
    if (a_vld) begin
      emit_o.res_a      = res_a;
      emit_o.res_a.last = !rst_emit;
      if (rst_emit) begin
        emit_o.res_b      = rst_res;
        emit_o.res_b.last = 1'b1;
        emit_o.count      = 2'd2;
      end else begin
        emit_o.count = 2'd1;
      end
    end else if (rst_emit) begin
      emit_o.res_a      = rst_res;
      emit_o.res_a.last = 1'b1;
      emit_o.count      = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      in_report_q <= 1'b0;
      hsum_q      <= '0;
      status_q    <= '0;
      request_q   <= '0;
      cnt_q       <= '0;
      chk_q       <= '0;
      rsum_q      <= '0;
      head_q      <= '{default: '0};
    end else begin
      byte_pos_q  <= byte_pos_d;
      in_report_q <= in_report_d;
      hsum_q      <= hsum_d;
      status_q    <= status_d;
      request_q   <= request_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      rsum_q      <= rsum_d;
      head_q      <= head_d;
    end
  end

  // A second result from one byte is always the reset request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.count == 2'd2 |-> emit_o.res_b.kind == trfd_pkg::KIND_RESET_REQ)
    else $error("second result is not a reset request");

  // Records are only taken once a nonzero, legal count was latched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_report_q && byte_pos_q > trfd_pkg::HdrLen) |->
      (cnt_q != 4'd0 && {1'b0, cnt_q} <= MaxC))
    else $error("record bytes taken without a valid contact count");

endmodule

`default_nettype wire

[rtl/core/trfd_rbuf.sv]
// Four-entry result buffer that takes up to two results per cycle.
`default_nettype none

module trfd_rbuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire trfd_pkg::emit_t    emit_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output trfd_pkg::result_t       out_data_o
);

  trfd_pkg::result_t entries_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = entries_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for the worst case of two results from the next byte.
  assign room_o      = (count_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (emit_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= emit_i.res_a;
    end
    if (emit_i.count == 2'd2) begin
      entries_q[wr_ptr_q + 2'd1] <= emit_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + emit_i.count;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, emit_i.count} - {2'b00, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result buffer overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.count != 2'd0 |-> room_o)
    else $error("results pushed without room");

endmodule

`default_nettype wire

[rtl/core/touch_report_frame_decoder.sv]
// Top level of the touch report frame decoder.
`default_nettype none

// Accepts one report byte per cycle. Each byte is registered, then parsed
// once the buffer has room, and its results (none, one or two) go into a
// four-entry result buffer. A byte that yields two results (report done
// or a header verdict followed by a reset request) occupies two buffer
// slots; input transfers stall only while the buffer has fewer than two
// free entries, so with the output side taking a result every cycle the
// rate is one byte per cycle. Results reach the output through the input
// register and the result buffer. The rotation pivot may be written at any
// time the block is idle; the configuration port is always ready.
module touch_report_frame_decoder #(
  parameter int unsigned MAX_CONTACTS = trfd_pkg::MaxContactsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire trfd_pkg::item_t    in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output trfd_pkg::result_t       out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [11:0]        cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  trfd_pkg::item_t   in_item_q;
  logic [11:0]       pivot_q, pivot_d;
  logic              room;
  logic              step;
  logic              accept;
  trfd_pkg::emit_t   emit;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && room;
  assign in_stall_o  = in_valid_q && !room;
  assign accept      = in_valid_i && !in_stall_o;
  assign pivot_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : pivot_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pivot_q    <= trfd_pkg::PivotReset;
    end else begin
      in_valid_q <= in_valid_d;
      pivot_q    <= pivot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_data_i;
    end
  end

  trfd_decode #(
    .MAX_CONTACTS(MAX_CONTACTS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .pivot_i(pivot_q),
    .emit_o (emit)
  );

  trfd_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Only a parsed byte can produce results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.count != 2'd0 |-> step)
    else $error("results produced without a byte in the parse stage");

  // A byte waiting in the input register is parsed as soon as there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && room) |=> (!in_valid_q || $past(accept)))
    else $error("input byte held despite buffer room");

endmodule

`default_nettype wire
